// ===== rtl/ssev_pkg.sv =====
// Shared types, constants and helpers for the state-space evaluator.
package ssev_pkg;

  localparam int LANES      = 4;
  localparam int WORD_W     = 32;
  localparam int COUNT_W    = 3;
  localparam int ADDR_W     = 6;
  localparam int MEM_DEPTH  = 64;
  localparam int VEC_N      = 2 * LANES;   // x then u
  localparam int PROD_W     = 2 * WORD_W;
  localparam int RND_W      = 48;          // rounded product, sign included
  localparam int ACC_W      = 51;          // up to eight rounded products

  localparam int IN_FIELDS_W = ADDR_W + WORD_W + VEC_N * WORD_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int VEC_LSB     = ADDR_W + WORD_W;
  localparam int OUT_TDATA_W = VEC_N * WORD_W;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic [1:0] REG_STATE_COUNT  = 2'd0;
  localparam logic [1:0] REG_INPUT_COUNT  = 2'd1;
  localparam logic [1:0] REG_OUTPUT_COUNT = 2'd2;

  localparam logic [1:0] SEL_A = 2'd0;
  localparam logic [1:0] SEL_B = 2'd1;
  localparam logic [1:0] SEL_C = 2'd2;
  localparam logic [1:0] SEL_D = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // One multiply-accumulate term issued to the datapath.
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        opnd;
    logic              first;
    logic              last;
    logic [2:0]        dest;
  } mac_cmd_t;

  typedef struct packed {
    logic mem_we;
    logic start;
    logic load_out;
  } dp_ctrl_t;

  typedef struct packed {
    logic busy;
  } dp_status_t;

  // Force a count into 1..limit.
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c,
                                                     input logic [COUNT_W-1:0] limit);
    logic [COUNT_W-1:0] top;
    top = (limit == '0) ? COUNT_W'(1) : limit;
    if (c == '0)
      return COUNT_W'(1);
    else if (c > top)
      return top;
    else
      return c;
  endfunction

endpackage

// ===== rtl/ssev_ctrl.sv =====
// Sequencer: handshakes, term issue order and output valid for the evaluator.
module ssev_ctrl
  import ssev_pkg::*;
#(
  parameter logic [COUNT_W-1:0] STATE_LIMIT  = 3'd4,
  parameter logic [COUNT_W-1:0] INPUT_LIMIT  = 3'd4,
  parameter logic [COUNT_W-1:0] OUTPUT_LIMIT = 3'd4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [COUNT_W-1:0] state_count,
  input  logic [COUNT_W-1:0] input_count,
  input  logic [COUNT_W-1:0] output_count,
  output mac_cmd_t           cmd,
  output dp_ctrl_t           ctrl,
  input  dp_status_t         status
);

  state_t state, state_next;

  logic [COUNT_W-1:0] ns, ni, no;
  logic [COUNT_W:0]   total;
  logic [COUNT_W-1:0] row_lim;
  logic               phase;
  logic [1:0]         row;
  logic [2:0]         term;
  logic               term_last, row_last, in_x;
  logic [1:0]         col;
  logic               accept, out_free;

  assign ns      = clamp_count(state_count, STATE_LIMIT);
  assign ni      = clamp_count(input_count, INPUT_LIMIT);
  assign no      = clamp_count(output_count, OUTPUT_LIMIT);
  assign total   = {1'b0, ns} + {1'b0, ni};
  assign row_lim = phase ? no : ns;

  assign term_last = (term == 3'(total - 4'd1));
  assign row_last  = ({1'b0, row} == 3'(row_lim - 3'd1));
  assign in_x      = (term < ns);
  assign col       = in_x ? term[1:0] : 2'(term - ns);

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (accept && s_axis_tuser == CMD_EVAL) state_next = ST_ISSUE;
      ST_ISSUE: if (phase && row_last && term_last) state_next = ST_DRAIN;
      ST_DRAIN: if (!status.busy) state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ctrl          = '0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ctrl.mem_we   = accept && (s_axis_tuser == CMD_LOAD);
        ctrl.start    = accept && (s_axis_tuser == CMD_EVAL);
      end
      ST_ISSUE: begin
        cmd.valid = 1'b1;
        cmd.addr  = {phase ? (in_x ? SEL_C : SEL_D) : (in_x ? SEL_A : SEL_B), row, col};
        cmd.opnd  = {!in_x, col};
        cmd.first = (term == 3'd0);
        cmd.last  = term_last;
        cmd.dest  = {phase, row};
      end
      ST_DONE: ctrl.load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Walk terms, then rows, then the A/B and C/D halves.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      row   <= 2'd0;
      term  <= 3'd0;
    end else if (ctrl.start) begin
      phase <= 1'b0;
      row   <= 2'd0;
      term  <= 3'd0;
    end else if (state == ST_ISSUE) begin
      if (term_last) begin
        term <= 3'd0;
        if (row_last) begin
          row   <= 2'd0;
          phase <= 1'b1;
        end else begin
          row <= row + 2'd1;
        end
      end else begin
        term <= term + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !s_axis_tready)
    else $error("input accepted while the MAC pipeline holds terms");

  a_done_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> !status.busy)
    else $error("result published before the pipeline drained");

  a_term_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ISSUE) |-> ({1'b0, term} < total))
    else $error("term counter past the column count");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |=> m_axis_tvalid)
    else $error("output register loaded without valid");

endmodule

// ===== rtl/ssev_dpath.sv =====
// Datapath: coefficient memory, operand registers, shared MAC pipeline, results.
module ssev_dpath
  import ssev_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  mac_cmd_t               cmd,
  input  dp_ctrl_t               ctrl,
  output dp_status_t             status
);

  logic [WORD_W-1:0] mem [MEM_DEPTH];
  logic [WORD_W-1:0] vec [VEC_N];
  logic [WORD_W-1:0] work [VEC_N];

  mac_cmd_t tag_a, tag_b, tag_c, tag_d;

  logic signed [WORD_W-1:0] coef_q, opnd_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [RND_W-1:0]  rnd;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod_biased;
  logic [WORD_W-1:0]        sat;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sh0000_0000_8000_0000);

  // Load transactions write the coefficient word directly.
  always_ff @(posedge clk) begin
    if (ctrl.mem_we) begin
      mem[s_axis_tdata[ADDR_W-1:0]] <= s_axis_tdata[ADDR_W +: WORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      for (int i = 0; i < VEC_N; i++) begin
        vec[i] <= s_axis_tdata[VEC_LSB + i*WORD_W +: WORD_W];
      end
    end
  end

  // Control tags travel beside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
      tag_b <= '0;
      tag_c <= '0;
      tag_d <= '0;
    end else begin
      tag_a <= cmd;
      tag_b <= tag_a;
      tag_c <= tag_b;
      tag_d <= tag_c;
    end
  end

  assign status.busy = tag_a.valid || tag_b.valid || tag_c.valid || tag_d.valid;

  // Stage A: read coefficient and select operand.
  always_ff @(posedge clk) begin
    coef_q <= mem[cmd.addr];
    opnd_q <= vec[cmd.opnd];
  end

  // Stage B: exact product.
  always_ff @(posedge clk) begin
    prod <= coef_q * opnd_q;
  end

  // Stage C: round to Q16.16, add half then floor.
  assign prod_biased = prod + PROD_W'(64'sd32768);

  always_ff @(posedge clk) begin
    rnd <= RND_W'(prod_biased >>> 16);
  end

  // Stage D: accumulate the row.
  always_ff @(posedge clk) begin
    if (tag_c.valid) begin
      acc <= tag_c.first ? ACC_W'(rnd) : acc + ACC_W'(rnd);
    end
  end

  always_comb begin
    if (acc > SAT_MAX)
      sat = 32'h7FFF_FFFF;
    else if (acc < SAT_MIN)
      sat = 32'h8000_0000;
    else
      sat = acc[WORD_W-1:0];
  end

  // Stage E: saturate and store the finished row; rows left unused stay zero.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      for (int i = 0; i < VEC_N; i++) begin
        work[i] <= '0;
      end
    end else if (tag_d.valid && tag_d.last) begin
      work[tag_d.dest] <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      for (int i = 0; i < VEC_N; i++) begin
        m_axis_tdata[i*WORD_W +: WORD_W] <= work[i];
      end
    end
  end

endmodule

// ===== rtl/state_space_evaluator.sv =====
// Evaluate item: the result is valid once all T terms have drained through the pipeline, where
// T = (ns + ni) * (ns + no) terms issued one per cycle into a single MAC pipeline.
// The next item is taken the cycle after the result enters the output register.
// Load item: writes one coefficient word; no result.
// Reset: counts to 4 states, 1 input, 1 output; coefficient memory undefined until written.
// Top level of the state-space evaluator: configuration registers and wiring.
module state_space_evaluator
  import ssev_pkg::*;
#(
  parameter int MAX_STATES  = 4,
  parameter int MAX_INPUTS  = 4,
  parameter int MAX_OUTPUTS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // coef_index, coef_value, state_in_0..3, drive_in_0..3, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // state_update_0..3, plant_out_0..3
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_addr,
  input  logic [COUNT_W-1:0]     cfg_data
);

  localparam logic [COUNT_W-1:0] STATE_LIMIT  =
    COUNT_W'((MAX_STATES < LANES) ? MAX_STATES : LANES);
  localparam logic [COUNT_W-1:0] INPUT_LIMIT  =
    COUNT_W'((MAX_INPUTS < LANES) ? MAX_INPUTS : LANES);
  localparam logic [COUNT_W-1:0] OUTPUT_LIMIT =
    COUNT_W'((MAX_OUTPUTS < LANES) ? MAX_OUTPUTS : LANES);

  logic [COUNT_W-1:0] state_count, input_count, output_count;

  mac_cmd_t   cmd;
  dp_ctrl_t   ctrl;
  dp_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state_count  <= 3'd4;
      input_count  <= 3'd1;
      output_count <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STATE_COUNT:  state_count  <= cfg_data;
        REG_INPUT_COUNT:  input_count  <= cfg_data;
        REG_OUTPUT_COUNT: output_count <= cfg_data;
        default: ;
      endcase
    end
  end

  ssev_ctrl #(
    .STATE_LIMIT  (STATE_LIMIT),
    .INPUT_LIMIT  (INPUT_LIMIT),
    .OUTPUT_LIMIT (OUTPUT_LIMIT)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .state_count   (state_count),
    .input_count   (input_count),
    .output_count  (output_count),
    .cmd           (cmd),
    .ctrl          (ctrl),
    .status        (status)
  );

  ssev_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tdata (m_axis_tdata),
    .cmd          (cmd),
    .ctrl         (ctrl),
    .status       (status)
  );

endmodule

// ===== tb/state_space_evaluator_tb.sv =====
// Self-checking testbench for the state-space evaluator: Q16.16 A/B/C/D model evaluation.
`timescale 1ns / 100ps

module state_space_evaluator_tb
  import ssev_pkg::*;
();

  localparam int MAX_ST        = 4;
  localparam int MAX_IN        = 4;
  localparam int MAX_OUT       = 4;
  localparam int PHASES        = 12;
  localparam int ITEMS_PER_PH  = 140;
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int PRINT_CAP     = 40;
  localparam longint SAT_HI    = 64'sd2147483647;
  localparam longint SAT_LO    = -64'sd2147483648;

  typedef struct packed {
    logic                            cmd;
    logic [ADDR_W-1:0]               index;
    logic [WORD_W-1:0]               value;
    logic [LANES-1:0][WORD_W-1:0]    x;
    logic [LANES-1:0][WORD_W-1:0]    u;
  } ss_cmd_t;

  typedef struct packed {
    logic [LANES-1:0][WORD_W-1:0]    upd;
    logic [LANES-1:0][WORD_W-1:0]    outp;
  } ss_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = CMD_LOAD;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_addr = REG_STATE_COUNT;
  logic [COUNT_W-1:0]     cfg_data = '0;

  // model state
  logic [WORD_W-1:0]  coef_mem [MEM_DEPTH];
  logic [COUNT_W-1:0] state_cnt, input_cnt, output_cnt;

  ss_cmd_t    cmd_q[$];
  ss_result_t ss_results_q[$];
  ss_cmd_t    cur_cmd;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int eval_count     = 0;
  int load_count     = 0;
  int cycle          = 0;

  state_space_evaluator #(
    .MAX_STATES (MAX_ST),
    .MAX_INPUTS (MAX_IN),
    .MAX_OUTPUTS(MAX_OUT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_CAP)
      $display("cycle %0d: mismatch: %s", cycle, msg);
  endtask

  function automatic int eff_count(input logic [COUNT_W-1:0] c, input int param_max);
    int lim;
    lim = (param_max < LANES) ? param_max : LANES;
    if (c == 0)
      return 1;
    if (int'(c) > lim)
      return lim;
    return int'(c);
  endfunction

  // One row of Mx*x + Mu*u: each product rounded to Q16.16, sum saturated.
  function automatic logic [WORD_W-1:0] mac_row(input int sel_x, input int sel_u, input int row,
                                                input ss_cmd_t c, input int nx, input int nu);
    longint acc;
    longint p;
    acc = 0;
    for (int col = 0; col < nx; col++) begin
      p = longint'(signed'(coef_mem[sel_x * 16 + row * 4 + col])) * longint'(signed'(c.x[col]));
      acc += (p + 64'sd32768) >>> 16;
    end
    for (int col = 0; col < nu; col++) begin
      p = longint'(signed'(coef_mem[sel_u * 16 + row * 4 + col])) * longint'(signed'(c.u[col]));
      acc += (p + 64'sd32768) >>> 16;
    end
    if (acc > SAT_HI)
      return 32'h7FFF_FFFF;
    else if (acc < SAT_LO)
      return 32'h8000_0000;
    else
      return acc[WORD_W-1:0];
  endfunction

  function automatic ss_result_t ss_evaluate(input ss_cmd_t c);
    ss_result_t r;
    int ns, ni, no;
    ns = eff_count(state_cnt, MAX_ST);
    ni = eff_count(input_cnt, MAX_IN);
    no = eff_count(output_cnt, MAX_OUT);
    r = '0;
    for (int row = 0; row < ns; row++)
      r.upd[row] = mac_row(int'(SEL_A), int'(SEL_B), row, c, ns, ni);
    for (int row = 0; row < no; row++)
      r.outp[row] = mac_row(int'(SEL_C), int'(SEL_D), row, c, ns, ni);
    return r;
  endfunction

  // Mix of extremes, full-range words and small values near unity.
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4, 5, 6: return $urandom();
      default: return 32'($urandom_range(0, 32'h3FFFF)) - 32'h20000;
    endcase
  endfunction

  function automatic ss_cmd_t load_cmd(input int idx, input logic [WORD_W-1:0] val);
    ss_cmd_t c;
    c.cmd   = CMD_LOAD;
    c.index = ADDR_W'(idx);
    c.value = val;
    for (int i = 0; i < LANES; i++) begin
      c.x[i] = $urandom();
      c.u[i] = $urandom();
    end
    return c;
  endfunction

  function automatic ss_cmd_t eval_cmd(input logic [LANES-1:0][WORD_W-1:0] x,
                                       input logic [LANES-1:0][WORD_W-1:0] u);
    ss_cmd_t c;
    c.cmd   = CMD_EVAL;
    c.index = ADDR_W'($urandom_range(0, MEM_DEPTH - 1));
    c.value = $urandom();
    c.x     = x;
    c.u     = u;
    return c;
  endfunction

  task automatic write_count(input logic [1:0] idx, input int val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= COUNT_W'(val);
  endtask

  // Mirror the count registers as the block takes them.
  always @(posedge clk) begin
    if (rst) begin
      state_cnt  <= COUNT_W'(4);
      input_cnt  <= COUNT_W'(1);
      output_cnt <= COUNT_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_STATE_COUNT:  state_cnt  <= cfg_data;
        REG_INPUT_COUNT:  input_cnt  <= cfg_data;
        REG_OUTPUT_COUNT: output_cnt <= cfg_data;
        default: ;
      endcase
    end
  end

  // Driver: predict on each accepted transaction, then offer the next command.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_cmd.cmd == CMD_LOAD) begin
          coef_mem[cur_cmd.index] = cur_cmd.value;
          load_count++;
        end else begin
          ss_results_q.push_back(ss_evaluate(cur_cmd));
          eval_count++;
        end
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_cmd = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_cmd.cmd;
          s_axis_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}},
                            cur_cmd.u, cur_cmd.x, cur_cmd.value, cur_cmd.index};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin : monitor
    ss_result_t want;
    ss_result_t got;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.upd  = m_axis_tdata[LANES*WORD_W-1:0];
        got.outp = m_axis_tdata[OUT_TDATA_W-1:LANES*WORD_W];
        if (ss_results_q.size() == 0) begin
          report_mismatch("result with no evaluation pending");
        end else begin
          want = ss_results_q.pop_front();
          for (int i = 0; i < LANES; i++) begin
            if (got.upd[i] !== want.upd[i])
              report_mismatch($sformatf("state_update_%0d got %h want %h",
                                        i, got.upd[i], want.upd[i]));
            if (got.outp[i] !== want.outp[i])
              report_mismatch($sformatf("plant_out_%0d got %h want %h",
                                        i, got.outp[i], want.outp[i]));
          end
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle, ss_results_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : sequencer
    int st_set [PHASES];
    int in_set [PHASES];
    int out_set[PHASES];
    logic [LANES-1:0][WORD_W-1:0] x, u;
    // extremes, zero counts and counts above the lane limit come first
    st_set  = '{4, 1, 4, 0, 7, 2, 3, 5, 0, 0, 0, 0};
    in_set  = '{1, 1, 4, 0, 7, 3, 2, 0, 0, 0, 0, 0};
    out_set = '{1, 1, 4, 0, 7, 1, 4, 6, 0, 0, 0, 0};
    for (int i = 8; i < PHASES; i++) begin
      st_set[i]  = $urandom_range(0, 7);
      in_set[i]  = $urandom_range(0, 7);
      out_set[i] = $urandom_range(0, 7);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      @(negedge clk);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      if (ph > 0) begin
        write_count(REG_STATE_COUNT, st_set[ph]);
        write_count(REG_INPUT_COUNT, in_set[ph]);
        write_count(REG_OUTPUT_COUNT, out_set[ph]);
        @(posedge clk);
        cfg_we <= 1'b0;
      end
      @(negedge clk);
      if (ph == 0) begin
        // every coefficient word is written before any evaluation reads it
        for (int i = 0; i < MEM_DEPTH; i++)
          cmd_q.push_back(load_cmd(i, rand_word()));
        cmd_q.push_back(load_cmd(int'(SEL_A) * 16, 32'h7FFF_FFFF));
        cmd_q.push_back(load_cmd(int'(SEL_B) * 16, 32'h8000_0000));
        cmd_q.push_back(load_cmd(int'(SEL_C) * 16, 32'h0001_0000));
        cmd_q.push_back(load_cmd(int'(SEL_D) * 16, 32'h0000_0001));
        cmd_q.push_back(eval_cmd({4{32'h7FFF_FFFF}}, {4{32'h7FFF_FFFF}}));
        cmd_q.push_back(eval_cmd({4{32'h8000_0000}}, {4{32'h8000_0000}}));
        cmd_q.push_back(eval_cmd('0, '0));
        // rounding at exactly one half and just below it, both signs
        cmd_q.push_back(eval_cmd('0, {96'h0, 32'h0000_8000}));
        cmd_q.push_back(eval_cmd('0, {96'h0, 32'hFFFF_8000}));
        cmd_q.push_back(eval_cmd('0, {96'h0, 32'h0000_7FFF}));
        cmd_q.push_back(eval_cmd('0, {96'h0, 32'hFFFF_7FFF}));
        cmd_q.push_back(load_cmd(int'(SEL_A) * 16, 32'h8000_0000));
        cmd_q.push_back(eval_cmd({4{32'h8000_0000}}, '0));
      end
      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        if ($urandom_range(0, 9) < 7) begin
          for (int i = 0; i < LANES; i++) begin
            x[i] = rand_word();
            u[i] = rand_word();
          end
          cmd_q.push_back(eval_cmd(x, u));
        end else begin
          cmd_q.push_back(load_cmd($urandom_range(0, MEM_DEPTH - 1), rand_word()));
        end
      end
      // drain, then hold off long enough for the block to go idle
      do
        @(negedge clk);
      while (cmd_q.size() != 0 || s_axis_tvalid || ss_results_q.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clk);
    end

    if (ss_results_q.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived", ss_results_q.size()));
    $display("Covered %0d evaluations and %0d coefficient loads over %0d count settings",
             eval_count, load_count, PHASES);
    $display("Flow control swept: free running, sparse sender, stalled receiver, mixed");
    if (err_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
